@@ hw/rtl/binary_min_heap_queue_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for binary_min_heap_queue
// Concurrent assertion shorthands clocked on clk_i, disabled while rst_ni low.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// Plain property, checked at every rising clock edge.
`define BMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define BMHQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  // Default sizes
  localparam int DEF_CAPACITY      = 256;
  localparam int DEF_KEY_WIDTH     = 32;
  localparam int DEF_PAYLOAD_WIDTH = 32;

  // Fixed port field widths
  localparam int MODE_W    = 1;
  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT  = 1'b0,
    MODE_EXTRACT = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_EX_RD,
    S_EX_LATCH,
    S_DN_CHK,
    S_DN_CMP,
    S_DONE
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic start_ins;   // accept insert: latch entry, pos = count, count++
    logic start_ex;    // accept extract: count--, pos = root
    logic start_rej;   // accept rejected transaction
    logic rd_parent;   // read parent of pos on port A
    logic up_step;     // move parent down into pos, pos = parent
    logic rd_ends;     // read root (A) and last entry (B)
    logic latch_ends;  // capture root as result, last entry as moving entry
    logic rd_kids;     // read left (A) and right (B) child of pos
    logic dn_step;     // move chosen child up into pos, pos = child
    logic wr_ent;      // write moving entry at pos
    logic load_out;    // load result register
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic parent_gt;
    logic no_kids;
    logic stop_down;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ hw/rtl/bmhq_if.sv @@
// ----------------------------------------------------------------------------
// bmhq request / response interfaces
// Valid/ready channels carrying heap operations and their results.
// ----------------------------------------------------------------------------
interface bmhq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [bmhq_pkg::MODE_W-1:0]          mode;
  logic signed [bmhq_pkg::KEY_W-1:0]    key;
  logic [bmhq_pkg::PAYLOAD_W-1:0]       payload;

  modport source (output valid, mode, key, payload, input ready);
  modport sink   (input valid, mode, key, payload, output ready);
endinterface

interface bmhq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [bmhq_pkg::STATUS_W-1:0]        status;
  logic signed [bmhq_pkg::KEY_W-1:0]    out_key;
  logic [bmhq_pkg::PAYLOAD_W-1:0]       out_payload;
  logic [bmhq_pkg::COUNT_W-1:0]         count;
  logic                                 is_empty;

  modport source (output valid, status, out_key, out_payload, count, is_empty,
                  input ready);
  modport sink   (input valid, status, out_key, out_payload, count, is_empty,
                  output ready);
endinterface

@@ hw/rtl/binary_min_heap_queue.sv @@
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Priority queue held as an array-based binary min-heap in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  (sink):   mode 0 inserts {key, payload}, mode 1 extracts the minimum.
//   rsp_o  (source): one result transaction per request: status, extracted
//                    key/payload (zero unless an extract succeeded), count and
//                    is_empty after the operation.
//   Rejections (insert when full, extract when empty) change nothing and
//   go straight to the result register.
//   Insert: per level the new entry climbs, S_UP_CHK reads the parent and
//   S_UP_CMP compares and moves. Extract: S_EX_RD reads root and last entry,
//   S_EX_LATCH latches them, then per level the last entry sinks, S_DN_CHK
//   reads both children and S_DN_CMP compares and moves. At most log2(CAPACITY)
//   levels are walked; memory has two registered read ports, one write port.
//   One request is worked on at a time; req_i.ready is high whenever the
//   sequencer is idle, even while a result still waits in the output register.
//   If rsp_o stalls, the finished operation holds until the register frees.
//   Reset empties the queue (count to zero); memory contents are not cleared
//   and no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
  parameter int CAPACITY      = bmhq_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH     = bmhq_pkg::DEF_KEY_WIDTH,
  parameter int PAYLOAD_WIDTH = bmhq_pkg::DEF_PAYLOAD_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmhq_req_if.sink   req_i,
  bmhq_rsp_if.source rsp_o
);

  bmhq_pkg::dp_cmd_t  cmd;
  bmhq_pkg::dp_stat_t stat;
  logic               req_ready;

  // Sequencer: walks the heap one level at a time
  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_mode_i  (req_i.mode),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  // Datapath: heap memory, count, sift position and result register
  bmhq_dp #(
    .CAPACITY      (CAPACITY),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_mode_i    (req_i.mode),
    .req_key_i     (req_i.key),
    .req_payload_i (req_i.payload),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_status_o  (rsp_o.status),
    .rsp_key_o     (rsp_o.out_key),
    .rsp_payload_o (rsp_o.out_payload),
    .rsp_count_o   (rsp_o.count),
    .rsp_empty_o   (rsp_o.is_empty)
  );

endmodule

@@ hw/rtl/bmhq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for insert sift-up and extract sift-down over the heap datapath.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_mode_i,
  output logic               req_ready_o,
  input  bmhq_pkg::dp_stat_t stat_i,
  output bmhq_pkg::dp_cmd_t  cmd_o
);

  bmhq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      bmhq_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (bmhq_pkg::mode_e'(req_mode_i) == bmhq_pkg::MODE_EXTRACT) begin
            if (stat_i.empty) begin
              cmd_o.start_rej = 1'b1;
              state_d         = bmhq_pkg::S_DONE;
            end else begin
              cmd_o.start_ex = 1'b1;
              state_d        = bmhq_pkg::S_EX_RD;
            end
          end else begin
            if (stat_i.full) begin
              cmd_o.start_rej = 1'b1;
              state_d         = bmhq_pkg::S_DONE;
            end else begin
              cmd_o.start_ins = 1'b1;
              state_d         = bmhq_pkg::S_UP_CHK;
            end
          end
        end
      end
      bmhq_pkg::S_UP_CHK: begin
        if (stat_i.at_root) begin
          cmd_o.wr_ent = 1'b1;
          state_d      = bmhq_pkg::S_DONE;
        end else begin
          cmd_o.rd_parent = 1'b1;
          state_d         = bmhq_pkg::S_UP_CMP;
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        if (stat_i.parent_gt) begin
          cmd_o.up_step = 1'b1;
          state_d       = bmhq_pkg::S_UP_CHK;
        end else begin
          cmd_o.wr_ent = 1'b1;
          state_d      = bmhq_pkg::S_DONE;
        end
      end
      bmhq_pkg::S_EX_RD: begin
        cmd_o.rd_ends = 1'b1;
        state_d       = bmhq_pkg::S_EX_LATCH;
      end
      bmhq_pkg::S_EX_LATCH: begin
        cmd_o.latch_ends = 1'b1;
        state_d          = bmhq_pkg::S_DN_CHK;
      end
      bmhq_pkg::S_DN_CHK: begin
        if (stat_i.no_kids) begin
          cmd_o.wr_ent = 1'b1;
          state_d      = bmhq_pkg::S_DONE;
        end else begin
          cmd_o.rd_kids = 1'b1;
          state_d       = bmhq_pkg::S_DN_CMP;
        end
      end
      bmhq_pkg::S_DN_CMP: begin
        if (stat_i.stop_down) begin
          cmd_o.wr_ent = 1'b1;
          state_d      = bmhq_pkg::S_DONE;
        end else begin
          cmd_o.dn_step = 1'b1;
          state_d       = bmhq_pkg::S_DN_CHK;
        end
      end
      bmhq_pkg::S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = bmhq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bmhq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/bmhq_dp.sv @@
// ----------------------------------------------------------------------------
// bmhq_dp
// Heap memory, entry count, sift position, key compares and result register.
// ----------------------------------------------------------------------------
module bmhq_dp #(
  parameter int CAPACITY      = bmhq_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH     = bmhq_pkg::DEF_KEY_WIDTH,
  parameter int PAYLOAD_WIDTH = bmhq_pkg::DEF_PAYLOAD_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bmhq_pkg::dp_cmd_t                    cmd_i,
  output bmhq_pkg::dp_stat_t                   stat_o,
  input  logic                                 req_mode_i,
  input  logic signed [bmhq_pkg::KEY_W-1:0]    req_key_i,
  input  logic [bmhq_pkg::PAYLOAD_W-1:0]       req_payload_i,
  output logic                                 rsp_valid_o,
  input  logic                                 rsp_ready_i,
  output logic [bmhq_pkg::STATUS_W-1:0]        rsp_status_o,
  output logic signed [bmhq_pkg::KEY_W-1:0]    rsp_key_o,
  output logic [bmhq_pkg::PAYLOAD_W-1:0]       rsp_payload_o,
  output logic [bmhq_pkg::COUNT_W-1:0]         rsp_count_o,
  output logic                                 rsp_empty_o
);

  localparam int IdxW    = $clog2(CAPACITY);
  localparam int CntW    = $clog2(CAPACITY + 1);
  localparam int ChW     = IdxW + 2;
  localparam int EntW    = KEY_WIDTH + PAYLOAD_WIDTH;
  localparam int OutKeyW = bmhq_pkg::KEY_W;
  localparam int OutPayW = bmhq_pkg::PAYLOAD_W;
  localparam int OutCntW = bmhq_pkg::COUNT_W;

  // entry layout: {key, payload}
  logic [EntW-1:0] mem [CAPACITY];
  logic [EntW-1:0] rd_a_q, rd_b_q;
  logic [IdxW-1:0] addr_a, addr_b, waddr;
  logic [EntW-1:0] wdata;
  logic            we;

  logic [CntW-1:0]          count_q, count_d;
  logic [IdxW-1:0]          pos_q, pos_d;
  logic [KEY_WIDTH-1:0]     ent_key_q, ent_key_d;
  logic [PAYLOAD_WIDTH-1:0] ent_pay_q, ent_pay_d;
  logic [KEY_WIDTH-1:0]     top_key_q, top_key_d;
  logic [PAYLOAD_WIDTH-1:0] top_pay_q, top_pay_d;
  bmhq_pkg::status_e        status_q, status_d;

  logic                          rsp_valid_q, rsp_valid_d;
  bmhq_pkg::status_e             rsp_status_q, rsp_status_d;
  logic signed [OutKeyW-1:0]     rsp_key_q, rsp_key_d;
  logic [OutPayW-1:0]            rsp_pay_q, rsp_pay_d;
  logic [OutCntW-1:0]            rsp_count_q, rsp_count_d;
  logic                          rsp_empty_q, rsp_empty_d;

  logic [IdxW-1:0] parent_idx, child_idx;
  logic [ChW-1:0]  lc, rc, n_ext;
  logic            rc_out, go_right;
  logic [EntW-1:0] child_ent;
  logic signed [KEY_WIDTH-1:0] a_key, b_key, m_key;

  // ---- index arithmetic ----
  assign parent_idx = (pos_q - IdxW'(1)) >> 1;
  assign lc         = {1'b0, pos_q, 1'b1};
  assign rc         = {1'b0, pos_q, 1'b0} + ChW'(2);
  assign n_ext      = ChW'(count_q);
  assign rc_out     = (rc >= n_ext);

  assign a_key = $signed(rd_a_q[EntW-1:PAYLOAD_WIDTH]);
  assign b_key = $signed(rd_b_q[EntW-1:PAYLOAD_WIDTH]);
  assign m_key = $signed(ent_key_q);

  // ties between children go right
  assign go_right  = !rc_out && !(a_key < b_key);
  assign child_idx = go_right ? rc[IdxW-1:0] : lc[IdxW-1:0];
  assign child_ent = go_right ? rd_b_q : rd_a_q;

  always_comb begin
    stat_o           = '0;
    stat_o.full      = (count_q == CntW'(CAPACITY));
    stat_o.empty     = (count_q == '0);
    stat_o.at_root   = (pos_q == '0);
    stat_o.parent_gt = (a_key > m_key);
    stat_o.no_kids   = (lc >= n_ext);
    stat_o.stop_down = rc_out ? (m_key <= a_key) : ((m_key <= a_key) && (m_key <= b_key));
    stat_o.out_busy  = rsp_valid_q && !rsp_ready_i;
  end

  // ---- memory ports ----
  always_comb begin
    addr_a = '0;
    addr_b = '0;
    if (cmd_i.rd_parent) begin
      addr_a = parent_idx;
    end else if (cmd_i.rd_kids) begin
      addr_a = lc[IdxW-1:0];
      addr_b = rc[IdxW-1:0];
    end else if (cmd_i.rd_ends) begin
      addr_b = count_q[IdxW-1:0];
    end
  end

  always_comb begin
    we    = cmd_i.up_step | cmd_i.dn_step | cmd_i.wr_ent;
    waddr = pos_q;
    if (cmd_i.up_step) begin
      wdata = rd_a_q;
    end else if (cmd_i.dn_step) begin
      wdata = child_ent;
    end else begin
      wdata = {ent_key_q, ent_pay_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  // ---- working registers ----
  always_comb begin
    count_d   = count_q;
    pos_d     = pos_q;
    ent_key_d = ent_key_q;
    ent_pay_d = ent_pay_q;
    top_key_d = top_key_q;
    top_pay_d = top_pay_q;
    status_d  = status_q;
    if (cmd_i.start_ins) begin
      ent_key_d = req_key_i[KEY_WIDTH-1:0];
      ent_pay_d = req_payload_i[PAYLOAD_WIDTH-1:0];
      pos_d     = count_q[IdxW-1:0];
      count_d   = count_q + CntW'(1);
      top_key_d = '0;
      top_pay_d = '0;
      status_d  = bmhq_pkg::ST_DONE;
    end
    if (cmd_i.start_ex) begin
      pos_d     = '0;
      count_d   = count_q - CntW'(1);
      top_key_d = '0;
      top_pay_d = '0;
      status_d  = bmhq_pkg::ST_DONE;
    end
    if (cmd_i.start_rej) begin
      top_key_d = '0;
      top_pay_d = '0;
      status_d  = (bmhq_pkg::mode_e'(req_mode_i) == bmhq_pkg::MODE_EXTRACT) ?
                  bmhq_pkg::ST_EMPTY : bmhq_pkg::ST_FULL;
    end
    if (cmd_i.latch_ends) begin
      top_key_d = rd_a_q[EntW-1:PAYLOAD_WIDTH];
      top_pay_d = rd_a_q[PAYLOAD_WIDTH-1:0];
      ent_key_d = rd_b_q[EntW-1:PAYLOAD_WIDTH];
      ent_pay_d = rd_b_q[PAYLOAD_WIDTH-1:0];
    end
    if (cmd_i.up_step) begin
      pos_d = parent_idx;
    end
    if (cmd_i.dn_step) begin
      pos_d = child_idx;
    end
  end

  // ---- result register ----
  always_comb begin
    rsp_valid_d  = rsp_valid_q && !rsp_ready_i;
    rsp_status_d = rsp_status_q;
    rsp_key_d    = rsp_key_q;
    rsp_pay_d    = rsp_pay_q;
    rsp_count_d  = rsp_count_q;
    rsp_empty_d  = rsp_empty_q;
    if (cmd_i.load_out) begin
      rsp_valid_d  = 1'b1;
      rsp_status_d = status_q;
      rsp_key_d    = OutKeyW'($signed(top_key_q));
      rsp_pay_d    = OutPayW'(top_pay_q);
      rsp_count_d  = OutCntW'(count_q);
      rsp_empty_d  = (count_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    ent_key_q    <= ent_key_d;
    ent_pay_q    <= ent_pay_d;
    top_key_q    <= top_key_d;
    top_pay_q    <= top_pay_d;
    status_q     <= status_d;
    rsp_status_q <= rsp_status_d;
    rsp_key_q    <= rsp_key_d;
    rsp_pay_q    <= rsp_pay_d;
    rsp_count_q  <= rsp_count_d;
    rsp_empty_q  <= rsp_empty_d;
  end

  assign rsp_valid_o   = rsp_valid_q;
  assign rsp_status_o  = rsp_status_q;
  assign rsp_key_o     = rsp_key_q;
  assign rsp_payload_o = rsp_pay_q;
  assign rsp_count_o   = rsp_count_q;
  assign rsp_empty_o   = rsp_empty_q;

endmodule

@@ hw/rtl/bmhq_chk.sv @@
// ----------------------------------------------------------------------------
// bmhq_chk
// Port-level checks on the heap queue result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_assert.svh"

module bmhq_chk #(
  parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 rsp_valid,
  input logic                                 rsp_ready,
  input logic [bmhq_pkg::STATUS_W-1:0]        status,
  input logic signed [bmhq_pkg::KEY_W-1:0]    out_key,
  input logic [bmhq_pkg::PAYLOAD_W-1:0]       out_payload,
  input logic [bmhq_pkg::COUNT_W-1:0]         count,
  input logic                                 is_empty
);

  localparam bit CountExact = (CAPACITY < (1 << bmhq_pkg::COUNT_W));

  `BMHQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
  `BMHQ_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable({status, out_key, out_payload, count, is_empty}), "result changed while stalled")
  `BMHQ_ASSERT_IMPL(a_count_max, rsp_valid && CountExact, int'(count) <= CAPACITY, "count above capacity")
  `BMHQ_ASSERT_IMPL(a_empty_flag, rsp_valid && CountExact, is_empty == (count == '0), "is_empty disagrees with count")
  `BMHQ_ASSERT_IMPL(a_reject_zero, rsp_valid && (status != bmhq_pkg::ST_DONE), (out_key == '0) && (out_payload == '0), "rejected result carries data")

endmodule

bind binary_min_heap_queue bmhq_chk #(
  .CAPACITY (CAPACITY)
) u_bmhq_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid   (rsp_o.valid),
  .rsp_ready   (rsp_o.ready),
  .status      (rsp_o.status),
  .out_key     (rsp_o.out_key),
  .out_payload (rsp_o.out_payload),
  .count       (rsp_o.count),
  .is_empty    (rsp_o.is_empty)
);
